/* hw/rtl/brf_pkg.sv */
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types, mode codes and vector offsets of the banked register file.
// ----------------------------------------------------------------------------
package brf_pkg;

    // operation codes
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_SWITCH = 2'd2,
        OP_EXCEPT = 2'd3
    } op_t;

    // processor mode codes
    localparam logic [4:0] MODE_USR = 5'h10;
    localparam logic [4:0] MODE_FIQ = 5'h11;
    localparam logic [4:0] MODE_IRQ = 5'h12;
    localparam logic [4:0] MODE_SVC = 5'h13;
    localparam logic [4:0] MODE_ABT = 5'h17;
    localparam logic [4:0] MODE_UND = 5'h1B;
    localparam logic [4:0] MODE_SYS = 5'h1F;

    // register index codes
    localparam logic [4:0] IDX_LAST_GPR = 5'd14;
    localparam logic [4:0] IDX_STATUS   = 5'd15;
    localparam logic [4:0] IDX_SAVED    = 5'd16;

    // exception vector offsets
    localparam logic [4:0] OFF_RESET = 5'd0;
    localparam logic [4:0] OFF_UNDEF = 5'd4;
    localparam logic [4:0] OFF_SWI   = 5'd8;
    localparam logic [4:0] OFF_PABT  = 5'd12;
    localparam logic [4:0] OFF_DABT  = 5'd16;
    localparam logic [4:0] OFF_IRQ   = 5'd24;
    localparam logic [4:0] OFF_FIQ   = 5'd28;

    localparam logic [15:0] HIGH_VEC_TOP = 16'hFFFF;

    // saved status bank slots
    localparam logic [2:0] SAVED_SVC = 3'd0;
    localparam logic [2:0] SAVED_ABT = 3'd1;
    localparam logic [2:0] SAVED_UND = 3'd2;
    localparam logic [2:0] SAVED_IRQ = 3'd3;
    localparam logic [2:0] SAVED_FIQ = 3'd4;

    // only the I bit and the mode bits of a status word can ever be nonzero
    typedef struct packed {
        logic       irq_mask;
        logic [4:0] mode;
    } status_t;

    localparam status_t STATUS_RESET = '{irq_mask: 1'b0, mode: MODE_SYS};

    // full 32-bit status word: mode 4:0, T bit 5 (always clear), I bit 7
    function automatic logic [31:0] status_word(input status_t s);
        return {24'd0, s.irq_mask, 2'b00, s.mode};
    endfunction

    // r13/r14 pair slot: 0 irq, 1 svc, 2 abt, 3 und
    function automatic logic [1:0] pair_slot(input logic [4:0] m);
        logic [1:0] slot;
        slot = 2'd0;
        case (m)
            MODE_IRQ: slot = 2'd0;
            MODE_SVC: slot = 2'd1;
            MODE_ABT: slot = 2'd2;
            MODE_UND: slot = 2'd3;
            default:  slot = 2'd0;
        endcase
        return slot;
    endfunction

    // saved status slot of a non-fiq privileged mode
    function automatic logic [2:0] spsr_slot(input logic [4:0] m);
        logic [2:0] slot;
        slot = SAVED_SVC;
        case (m)
            MODE_SVC: slot = SAVED_SVC;
            MODE_ABT: slot = SAVED_ABT;
            MODE_UND: slot = SAVED_UND;
            MODE_IRQ: slot = SAVED_IRQ;
            default:  slot = SAVED_FIQ;
        endcase
        return slot;
    endfunction

    // irq, svc, abt or und
    function automatic logic is_pair_mode(input logic [4:0] m);
        return (m == MODE_IRQ) || (m == MODE_SVC) || (m == MODE_ABT) || (m == MODE_UND);
    endfunction

endpackage

/* hw/rtl/brf_if.sv */
// ----------------------------------------------------------------------------
// brf_req_if / brf_rsp_if
// Valid/ready channels carrying request and result words of the register file.
// ----------------------------------------------------------------------------
interface brf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [4:0]  reg_index;
    logic [31:0] write_data;
    logic [4:0]  new_mode;
    logic [4:0]  exception_offset;
    logic [31:0] return_address;

    modport source (
        output valid, operation, reg_index, write_data, new_mode,
               exception_offset, return_address,
        input  ready
    );
    modport sink (
        input  valid, operation, reg_index, write_data, new_mode,
               exception_offset, return_address,
        output ready
    );
endinterface

interface brf_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [4:0]  previous_mode;
    logic [31:0] status_word;
    logic [31:0] vector_address;
    logic        error;

    modport source (
        output valid, read_data, previous_mode, status_word, vector_address, error,
        input  ready
    );
    modport sink (
        input  valid, read_data, previous_mode, status_word, vector_address, error,
        output ready
    );
endinterface

/* hw/rtl/banked_register_file_mode_switch_core.sv */
// ----------------------------------------------------------------------------
// banked_register_file_mode_switch_core
// Mode-banked register file with read, write, mode switch and exception entry.
// ----------------------------------------------------------------------------
// usage
//   req carries one request word: operation, reg_index, write_data, new_mode,
//   exception_offset and return_address. rsp returns one result word per
//   request, in order: read_data, previous_mode, status_word, vector_address
//   and error. A word moves on a rising edge with valid and ready both high.
//   cfg_we/cfg_wdata write the high_vectors bit; write it only while idle.
// pipeline and throughput
//   A request is captured in an input register, executed by one pass of
//   logic that updates the banks once the result register is free or being
//   read, and its result is held in an output register that drives rsp.valid.
//   One request per cycle is sustained while rsp.ready stays high; the input
//   register and the result register let a new word enter while a finished
//   result waits.
// reset
//   All banks clear to zero, status and saved status to system mode with
//   the I bit clear, high_vectors to zero, both channels empty.
// stall
//   While rsp.ready is low the result holds, the pending request waits in
//   the input register, and req.ready drops once that register is full.
// ----------------------------------------------------------------------------
module banked_register_file_mode_switch_core
    import brf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_we,
    input  logic      cfg_wdata,
    brf_req_if.sink   req,
    brf_rsp_if.source rsp
);

    // input register
    logic        in_valid_reg;
    op_t         in_op_reg;
    logic [4:0]  in_idx_reg;
    logic [31:0] in_wdata_reg;
    logic [4:0]  in_nmode_reg;
    logic [4:0]  in_off_reg;
    logic [31:0] in_raddr_reg;

    // architectural state
    logic [31:0] gr_reg   [15];
    logic [31:0] fiq_reg  [7];
    logic [31:0] usl_reg  [2];
    logic [31:0] msl_reg  [8];
    status_t     spsr_reg [5];
    status_t     cs_reg;
    status_t     css_reg;
    logic        hv_reg;

    logic [31:0] gr_next   [15];
    logic [31:0] fiq_next  [7];
    logic [31:0] usl_next  [2];
    logic [31:0] msl_next  [8];
    status_t     spsr_next [5];
    status_t     cs_next;
    status_t     css_next;

    // result register
    logic        out_valid_reg;
    logic [31:0] out_rdata_reg;
    logic [4:0]  out_prev_reg;
    status_t     out_status_reg;
    logic [31:0] out_vec_reg;
    logic        out_err_reg;

    logic        advance;
    logic        exc_ok;
    logic [4:0]  exc_mode;
    logic [31:0] res_rdata;
    logic [4:0]  res_prev;
    logic [31:0] res_vec;
    logic        res_err;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    // vector offset to exception mode
    always_comb
    begin
        exc_ok   = 1'b1;
        exc_mode = MODE_SVC;
        case (in_off_reg) inside
            OFF_RESET, OFF_SWI: exc_mode = MODE_SVC;
            OFF_UNDEF:          exc_mode = MODE_UND;
            OFF_PABT, OFF_DABT: exc_mode = MODE_ABT;
            OFF_IRQ:            exc_mode = MODE_IRQ;
            OFF_FIQ:            exc_mode = MODE_FIQ;
            default:            exc_ok   = 1'b0;
        endcase
    end

    // one pass of the requested operation over the banks
    always_comb
    begin
        logic        do_sw;
        logic [4:0]  old_mode;
        logic [4:0]  sw_mode;
        logic [31:0] tmp;

        gr_next   = gr_reg;
        fiq_next  = fiq_reg;
        usl_next  = usl_reg;
        msl_next  = msl_reg;
        spsr_next = spsr_reg;
        cs_next   = cs_reg;
        css_next  = css_reg;
        res_rdata = 32'd0;
        res_prev  = 5'd0;
        res_vec   = 32'd0;
        res_err   = 1'b0;
        old_mode  = cs_reg.mode;
        tmp       = 32'd0;

        do_sw   = (in_op_reg == OP_SWITCH) || ((in_op_reg == OP_EXCEPT) && exc_ok);
        sw_mode = (in_op_reg == OP_EXCEPT) ? exc_mode : in_nmode_reg;

        // read and write of registers; previous mode of a switch or exception
        case (in_op_reg)
            OP_READ:
            begin
                if (in_idx_reg <= IDX_LAST_GPR)
                    res_rdata = gr_reg[in_idx_reg[3:0]];
                else if (in_idx_reg == IDX_STATUS)
                    res_rdata = status_word(cs_reg);
                else if (in_idx_reg == IDX_SAVED)
                    res_rdata = status_word(css_reg);
                else
                    res_err = 1'b1;
            end
            OP_WRITE:
            begin
                if (in_idx_reg <= IDX_LAST_GPR)
                    gr_next[in_idx_reg[3:0]] = in_wdata_reg;
                else
                    res_err = 1'b1;
            end
            OP_SWITCH:
            begin
                res_prev = old_mode;
            end
            default:
            begin
                res_prev = old_mode;
                if (!exc_ok)
                    res_err = 1'b1;
            end
        endcase

        if (do_sw)
        begin
            // store the outgoing bank
            if ((old_mode == MODE_USR) || (old_mode == MODE_SYS))
            begin
                usl_next[0] = gr_reg[13];
                usl_next[1] = gr_reg[14];
            end
            else if (old_mode == MODE_FIQ)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    gr_next[4'(8 + i)] = fiq_reg[i];
                    fiq_next[i]        = gr_reg[4'(8 + i)];
                end
                fiq_next[5]          = gr_reg[13];
                fiq_next[6]          = gr_reg[14];
                spsr_next[SAVED_FIQ] = css_reg;
            end
            else if (is_pair_mode(old_mode))
            begin
                msl_next[{pair_slot(old_mode), 1'b0}] = gr_reg[13];
                msl_next[{pair_slot(old_mode), 1'b1}] = gr_reg[14];
                spsr_next[spsr_slot(old_mode)]         = css_reg;
            end

            // load the incoming bank
            if ((sw_mode == MODE_USR) || (sw_mode == MODE_SYS))
            begin
                gr_next[13] = usl_next[0];
                gr_next[14] = usl_next[1];
            end
            else if (sw_mode == MODE_FIQ)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    tmp                = gr_next[4'(8 + i)];
                    gr_next[4'(8 + i)] = fiq_next[i];
                    fiq_next[i]        = tmp;
                end
                gr_next[13] = fiq_next[5];
                gr_next[14] = fiq_next[6];
                css_next    = spsr_next[SAVED_FIQ];
            end
            else if (is_pair_mode(sw_mode))
            begin
                gr_next[13] = msl_next[{pair_slot(sw_mode), 1'b0}];
                gr_next[14] = msl_next[{pair_slot(sw_mode), 1'b1}];
                css_next    = spsr_next[spsr_slot(sw_mode)];
            end
            else if (in_op_reg == OP_SWITCH)
            begin
                res_err = 1'b1;
            end
            cs_next.mode = sw_mode;

            // exception entry extras
            if (in_op_reg == OP_EXCEPT)
            begin
                gr_next[14]      = in_raddr_reg;
                css_next         = cs_reg;
                cs_next.irq_mask = 1'b1;
                res_vec          = {hv_reg ? HIGH_VEC_TOP : 16'd0, 11'd0, in_off_reg};
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (req.ready)
            in_valid_reg <= req.valid;
    end

    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_op_reg    <= op_t'(req.operation);
            in_idx_reg   <= req.reg_index;
            in_wdata_reg <= req.write_data;
            in_nmode_reg <= req.new_mode;
            in_off_reg   <= req.exception_offset;
            in_raddr_reg <= req.return_address;
        end
    end

    // banked state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gr_reg   <= '{default: 32'd0};
            fiq_reg  <= '{default: 32'd0};
            usl_reg  <= '{default: 32'd0};
            msl_reg  <= '{default: 32'd0};
            spsr_reg <= '{default: status_t'(6'd0)};
            cs_reg   <= STATUS_RESET;
            css_reg  <= STATUS_RESET;
            hv_reg   <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                gr_reg   <= gr_next;
                fiq_reg  <= fiq_next;
                usl_reg  <= usl_next;
                msl_reg  <= msl_next;
                spsr_reg <= spsr_next;
                cs_reg   <= cs_next;
                css_reg  <= css_next;
            end
            if (cfg_we)
                hv_reg <= cfg_wdata;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_rdata_reg  <= res_rdata;
            out_prev_reg   <= res_prev;
            out_status_reg <= cs_next;
            out_vec_reg    <= res_vec;
            out_err_reg    <= res_err;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.read_data      = out_rdata_reg;
    assign rsp.previous_mode  = out_prev_reg;
    assign rsp.status_word    = status_word(out_status_reg);
    assign rsp.vector_address = out_vec_reg;
    assign rsp.error          = out_err_reg;

    // checks
    a_switch_sets_mode: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_SWITCH) |=> cs_reg.mode == $past(in_nmode_reg))
        else $error("mode bits do not follow a mode switch");

    a_entry_masks_irq: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_EXCEPT) && exc_ok |=> cs_reg.irq_mask && out_valid_reg)
        else $error("exception entry left irq unmasked");

    a_bad_vector_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_op_reg == OP_EXCEPT) && !exc_ok |=> $stable(cs_reg) && $stable(css_reg))
        else $error("reserved vector changed status");

    a_error_no_vector: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_vec_reg == 32'd0)
        else $error("vector given with error");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> req.ready)
        else $error("input stalled while input register empty");

endmodule
